@@ src/bbrf_pkg.sv @@
// Package for the burst byte ring FIFO: status codes, field widths, defaults
// and small helper functions. No dependencies.
package bbrf_pkg;

	localparam int unsigned DEPTH_DEF     = 16;
	localparam int unsigned MAX_BURST_DEF = 8;

	localparam int unsigned LEN_W    = 4;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned DELAY_W  = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BYTES    = DATA_W / 8;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [DELAY_W-1:0] WORD_DELAY_NS = 7'd50;

	// bus delay: 50 ns per started 4-byte word, word count taken modulo four
	function automatic logic [DELAY_W-1:0] burst_delay(input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] words;
		words = (n + 4'd3) >> 2;
		return DELAY_W'(words[1:0] * WORD_DELAY_NS);
	endfunction

	// lane count: power of two covering the burst, at least two, at most eight
	function automatic int unsigned lane_count(input int unsigned max_burst);
		if (max_burst <= 2)
			return 2;
		else if (max_burst <= 4)
			return 4;
		else
			return 8;
	endfunction

endpackage

@@ src/bbrf_if.sv @@
// Handshake channels of the burst byte ring FIFO: request and response.
// Depends on bbrf_pkg.
interface bbrf_req_if
	import bbrf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [LEN_W-1:0]  length;
	logic [DATA_W-1:0] write_bytes;

	modport source (output valid, operation, length, write_bytes, input ready);
	modport sink   (input valid, operation, length, write_bytes, output ready);
endinterface

interface bbrf_rsp_if
	import bbrf_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    moved_length;
	logic [DATA_W-1:0]   read_bytes;
	logic [DELAY_W-1:0]  delay_ns;

	modport source (output valid, status, moved_length, read_bytes, delay_ns, input ready);
	modport sink   (input valid, status, moved_length, read_bytes, delay_ns, output ready);
endinterface

@@ src/burst_byte_ring_fifo.sv @@
// Top level of the burst byte ring FIFO: request register, banked byte store,
// response register. Depends on bbrf_pkg and the channels in bbrf_if.sv.
//
// Circular byte FIFO of DEPTH bytes serving one write or read burst of up to
// MAX_BURST bytes per transaction. Requests are taken one per cycle unless the
// response register is full and not taken; each passes a request register, then
// the store access, and its response is held in the response register until it
// is taken. The store is split into byte lanes (a power of two from two to
// eight, not below MAX_BURST when it is at most eight), each a small memory with
// one write and one registered read port, so a burst touches every lane at most
// once. A write into a full FIFO or a read from an empty one returns error and
// changes nothing; a length above MAX_BURST is clipped to it, and a request
// beyond the room or the fill is shortened and reported incomplete. No clearing
// pass is needed after reset.
module burst_byte_ring_fifo
	import bbrf_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bbrf_req_if.sink     req,
	bbrf_rsp_if.source   rsp
);

	localparam int unsigned NL   = lane_count(MAX_BURST);
	localparam int unsigned LW   = $clog2(NL);
	localparam int unsigned ROWS = (DEPTH + NL - 1) / NL;
	localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	// compare width: room and fill may be narrower than a burst length
	localparam int unsigned SW   = (CW > LEN_W) ? CW : LEN_W;

	localparam logic [RW-1:0]    LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0]    FULL_CNT = CW'(DEPTH);
	localparam logic [LEN_W-1:0] BURST    = LEN_W'(MAX_BURST);

	// request stage
	logic              v_s1;
	logic              op_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [DATA_W-1:0] wdata_s1;

	// response stage
	logic                v_s2;
	logic                op_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [LEN_W-1:0]    n_s2;
	logic [LW-1:0]       lane_s2;
	logic [DELAY_W-1:0]  delay_s2;
	logic [7:0]          rd_s2 [NL];

	// ring state
	logic [RW-1:0] wrow_q, rrow_q;
	logic [LW-1:0] wlane_q, rlane_q;
	logic [CW-1:0] fill_q;

	logic [7:0] bank_q [NL][ROWS];

	logic adv;
	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;

	function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
		return (r == LAST_ROW) ? '0 : r + 1'b1;
	endfunction

	// burst sizing
	logic [LEN_W-1:0]    req_len;
	logic [CW-1:0]       room;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    n;

	always_comb begin
		req_len = (len_s1 > BURST) ? BURST : len_s1;
		room    = FULL_CNT - fill_q;
		status  = ST_OK;
		n       = req_len;
		if (op_s1 == OP_WRITE) begin
			if (fill_q == FULL_CNT) begin
				status = ST_ERROR;
				n      = '0;
			end else if (SW'(req_len) > SW'(room)) begin
				status = ST_INCOMPLETE;
				n      = LEN_W'(room);
			end
		end else begin
			if (fill_q == '0) begin
				status = ST_ERROR;
				n      = '0;
			end else if (SW'(req_len) > SW'(fill_q)) begin
				status = ST_INCOMPLETE;
				n      = LEN_W'(fill_q);
			end
		end
	end

	logic          do_wr, do_rd;
	logic [LW:0]   wsum, rsum;
	assign do_wr = adv && (op_s1 == OP_WRITE);
	assign do_rd = adv && (op_s1 == OP_READ);
	assign wsum  = {1'b0, wlane_q} + (LW+1)'(n);
	assign rsum  = {1'b0, rlane_q} + (LW+1)'(n);

	// per-lane addresses; lanes below the start lane belong to the next row
	logic [RW-1:0] wr_row [NL];
	logic [RW-1:0] rd_row [NL];
	logic          wr_en  [NL];
	logic [7:0]    wr_byte[NL];

	always_comb begin
		for (int j = 0; j < NL; j++) begin
			logic [LW-1:0] k;
			k          = LW'(j) - wlane_q;
			wr_en[j]   = do_wr && (LEN_W'(k) < n);
			wr_row[j]  = (LW'(j) < wlane_q) ? row_inc(wrow_q) : wrow_q;
			wr_byte[j] = wdata_s1[8*k +: 8];
			rd_row[j]  = (LW'(j) < rlane_q) ? row_inc(rrow_q) : rrow_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NL; j++) begin
			if (wr_en[j])
				bank_q[j][wr_row[j]] <= wr_byte[j];
			if (adv)
				rd_s2[j] <= bank_q[j][rd_row[j]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			wrow_q  <= '0;
			rrow_q  <= '0;
			wlane_q <= '0;
			rlane_q <= '0;
			fill_q  <= '0;
		end else begin
			if (req.ready)
				v_s1 <= req.valid;
			if (adv)
				v_s2 <= 1'b1;
			else if (rsp.ready)
				v_s2 <= 1'b0;
			if (do_wr) begin
				wlane_q <= wsum[LW-1:0];
				if (wsum[LW])
					wrow_q <= row_inc(wrow_q);
				fill_q <= fill_q + CW'(n);
			end
			if (do_rd) begin
				rlane_q <= rsum[LW-1:0];
				if (rsum[LW])
					rrow_q <= row_inc(rrow_q);
				fill_q <= fill_q - CW'(n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.operation;
			len_s1   <= req.length;
			wdata_s1 <= req.write_bytes;
		end
		if (adv) begin
			op_s2     <= op_s1;
			status_s2 <= status;
			n_s2      <= n;
			lane_s2   <= rlane_q;
			delay_s2  <= burst_delay(n);
		end
	end

	// reorder lanes into burst order, zero unused bytes
	always_comb begin
		rsp.read_bytes = '0;
		for (int k = 0; k < NL; k++) begin
			logic [LW-1:0] lane;
			lane = lane_s2 + LW'(k);
			if ((op_s2 == OP_READ) && (LEN_W'(k) < n_s2))
				rsp.read_bytes[8*k +: 8] = rd_s2[lane];
		end
	end

	assign rsp.valid        = v_s2;
	assign rsp.status       = status_s2;
	assign rsp.moved_length = n_s2;
	assign rsp.delay_ns     = delay_s2;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for burst_byte_ring_fifo: a directed table, then random bursts,
// checked against an in-bench ring model. Depends on bbrf_pkg and the channels in bbrf_if.sv.
module testbench
	import bbrf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH        = DEPTH_DEF;
	localparam int unsigned MAX_BURST    = MAX_BURST_DEF;
	localparam int unsigned RANDOM_ITEMS = 1680;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned MAX_PRINTED  = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    moved;
		logic [DATA_W-1:0]   rdata;
		logic [DELAY_W-1:0]  delay;
	} burst_rsp_t;

	typedef struct packed {
		logic              op;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic              typed;  // take want as is instead of the ring model
		burst_rsp_t        want;
	} burst_req_t;

	localparam burst_rsp_t UNTYPED = '0;

	localparam burst_req_t DIRECTED [23] = '{
		// empty: error even for zero length
		'{OP_READ,  4'd0,  64'd0, 1'b1, '{ST_ERROR, 4'd0, 64'd0, 7'd0}},
		'{OP_READ,  4'd15, 64'd0, 1'b1, '{ST_ERROR, 4'd0, 64'd0, 7'd0}},
		'{OP_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 4'd0, 64'd0, 7'd0}},
		'{OP_WRITE, 4'd3,  64'h1122_3344_55AA_BBCC, 1'b1, '{ST_OK, 4'd3, 64'd0, 7'd50}},
		'{OP_READ,  4'd3,  64'd0, 1'b0, UNTYPED},
		'{OP_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 4'd8, 64'd0, 7'd100}},
		// length above the burst limit is clipped, still ok; fills and wraps
		'{OP_WRITE, 4'd15, 64'h0123_4567_89AB_CDEF, 1'b1, '{ST_OK, 4'd8, 64'd0, 7'd100}},
		'{OP_WRITE, 4'd1,  64'h0000_0000_0000_00A5, 1'b1, '{ST_ERROR, 4'd0, 64'd0, 7'd0}},
		'{OP_WRITE, 4'd0,  64'd0, 1'b1, '{ST_ERROR, 4'd0, 64'd0, 7'd0}},
		'{OP_READ,  4'd0,  64'd0, 1'b1, '{ST_OK, 4'd0, 64'd0, 7'd0}},
		'{OP_READ,  4'd1,  64'd0, 1'b0, UNTYPED},
		'{OP_READ,  4'd12, 64'd0, 1'b0, UNTYPED},
		'{OP_WRITE, 4'd8,  64'd0, 1'b1, '{ST_OK, 4'd8, 64'd0, 7'd100}},
		// one byte of room left: shortened write
		'{OP_WRITE, 4'd5,  64'h0000_00C3_5A96_E1F0, 1'b1, '{ST_INCOMPLETE, 4'd1, 64'd0, 7'd50}},
		'{OP_READ,  4'd8,  64'd0, 1'b0, UNTYPED},
		'{OP_READ,  4'd8,  64'd0, 1'b0, UNTYPED},
		'{OP_READ,  4'd8,  64'd0, 1'b1, '{ST_ERROR, 4'd0, 64'd0, 7'd0}},
		'{OP_WRITE, 4'd4,  64'h8000_0001_1122_3344, 1'b1, '{ST_OK, 4'd4, 64'd0, 7'd50}},
		// fewer bytes stored than asked: shortened read
		'{OP_READ,  4'd7,  64'd0, 1'b0, UNTYPED},
		'{OP_WRITE, 4'd5,  64'hDEAD_BEEF_CAFE_F00D, 1'b1, '{ST_OK, 4'd5, 64'd0, 7'd100}},
		'{OP_READ,  4'd5,  64'd0, 1'b0, UNTYPED},
		'{OP_WRITE, 4'd8,  64'd0, 1'b1, '{ST_OK, 4'd8, 64'd0, 7'd100}},
		'{OP_READ,  4'd8,  64'd0, 1'b1, '{ST_OK, 4'd8, 64'd0, 7'd100}}
	};

	logic clk = 1'b0;
	logic arst_n;

	bbrf_req_if req_ch ();
	bbrf_rsp_if rsp_ch ();

	burst_byte_ring_fifo #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ring model state
	logic [7:0]  ring_mem [DEPTH];
	int unsigned wr_idx;
	int unsigned rd_idx;
	int unsigned ring_count;

	burst_req_t  in_flight [$];    // driven, not yet accepted
	burst_rsp_t  pending_rsp [$];  // accepted, response not yet seen
	int unsigned errors;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic burst_rsp_t ring_apply(input burst_req_t b);
		burst_rsp_t  r;
		int unsigned asked;
		int unsigned n;
		int unsigned room;
		r = '0;
		n = 0;
		asked = b.len;
		if (asked > MAX_BURST)
			asked = MAX_BURST;
		if (b.op == OP_WRITE) begin
			if (ring_count >= DEPTH) begin
				r.status = ST_ERROR;
			end else begin
				room = DEPTH - ring_count;
				n = (asked > room) ? room : asked;
				r.status = (asked > room) ? ST_INCOMPLETE : ST_OK;
				for (int unsigned i = 0; i < n; i++)
					ring_mem[(wr_idx + i) % DEPTH] = b.data[8*i +: 8];
				wr_idx = (wr_idx + n) % DEPTH;
				ring_count += n;
			end
		end else if (ring_count == 0) begin
			r.status = ST_ERROR;
		end else begin
			n = (asked > ring_count) ? ring_count : asked;
			r.status = (asked > ring_count) ? ST_INCOMPLETE : ST_OK;
			for (int unsigned i = 0; i < n; i++)
				r.rdata[8*i +: 8] = ring_mem[(rd_idx + i) % DEPTH];
			rd_idx = (rd_idx + n) % DEPTH;
			ring_count -= n;
		end
		r.moved = LEN_W'(n);
		r.delay = DELAY_W'(((n + 3) / 4) * WORD_DELAY_NS);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	// request accept and response check in one process, so same-edge order is fixed
	always @(posedge clk) begin
		burst_req_t acc;
		burst_rsp_t seen;
		burst_rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (in_flight.size() == 0) begin
					report_mismatch("request accepted while none was driven");
				end else begin
					acc = in_flight.pop_front();
					want = ring_apply(acc);
					pending_rsp.push_back(acc.typed ? acc.want : want);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen = '{rsp_ch.status, rsp_ch.moved_length, rsp_ch.read_bytes, rsp_ch.delay_ns};
				if (pending_rsp.size() == 0) begin
					report_mismatch("response transaction with none expected");
				end else begin
					want = pending_rsp.pop_front();
					if (seen.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							seen.status, want.status));
					if (seen.moved !== want.moved)
						report_mismatch($sformatf("moved_length %0d, expected %0d",
							seen.moved, want.moved));
					if (seen.rdata !== want.rdata)
						report_mismatch($sformatf("read_bytes %h, expected %h",
							seen.rdata, want.rdata));
					if (seen.delay !== want.delay)
						report_mismatch($sformatf("delay_ns %0d, expected %0d",
							seen.delay, want.delay));
				end
			end
		end
	end

	// response backpressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_burst(input burst_req_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= b.op;
		req_ch.length      <= b.len;
		req_ch.write_bytes <= b.data;
		in_flight.push_back(b);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// caller drops valid first; always advances at least one edge
	task automatic wait_drained();
		do
			@(posedge clk);
		while (in_flight.size() + pending_rsp.size() != 0);
	endtask

	initial begin
		burst_req_t item;
		logic       write_heavy;
		errors       = 0;
		wr_idx       = 0;
		rd_idx       = 0;
		ring_count   = 0;
		src_idle_pct = 10;
		snk_idle_pct = 66;
		write_heavy  = 1'b1;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_WRITE;
		req_ch.length       = '0;
		req_ch.write_bytes  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_burst(DIRECTED[i]);

		for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3 || k == 2 * RANDOM_ITEMS / 3) begin
				// hold off until the FIFO has answered everything, then change idling: swapped first, none second
				req_ch.valid <= 1'b0;
				wait_drained();
				src_idle_pct = (k == RANDOM_ITEMS / 3) ? 66 : 0;
				snk_idle_pct = (k == RANDOM_ITEMS / 3) ? 10 : 0;
			end
			// drift between filling and draining so full and empty both get hit
			if ($urandom_range(39) == 0)
				write_heavy = !write_heavy;
			item.op = ($urandom_range(99) < (write_heavy ? 75 : 25)) ? OP_WRITE : OP_READ;
			item.len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15, 9))
				: LEN_W'($urandom_range(8));
			item.data  = {$urandom, $urandom};
			item.typed = 1'b0;
			item.want  = UNTYPED;
			send_burst(item);
		end

		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
